FILE: design/dmsc_pkg.sv
// Shared types and codes for the direct-mapped search cache.
// Used by dmsc_table, dmsc_eval and direct_mapped_search_cache. No dependencies.
package dmsc_pkg;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] KIND_PROBE = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Bound kinds of a stored entry.
    localparam logic [1:0] FLAG_EXACT = 2'd0;
    localparam logic [1:0] FLAG_UPPER = 2'd1;
    localparam logic [1:0] FLAG_LOWER = 2'd2;

    // Mate scores lie beyond this magnitude.
    localparam logic signed [16:0] MATE_LIMIT = 17'sd20000;
    localparam logic signed [16:0] SCORE_MAX  = 17'sd32767;
    localparam logic signed [16:0] SCORE_MIN  = -17'sd32768;

    localparam int KEY_W   = 64;
    localparam int DATA_W  = 42;
    localparam int SLOT_W  = KEY_W + DATA_W;
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 3;

    // Data word of one slot; score sits in the lowest bits.
    typedef struct packed {
        logic [1:0]         flag;
        logic signed [7:0]  depth;
        logic [15:0]        move;
        logic signed [15:0] score;
    } data_t;

    // One slot: key in the low bits, data word above it.
    typedef struct packed {
        data_t              data;
        logic [KEY_W-1:0]   key;
    } slot_t;

    // Payload fields of one input item (kind travels separately).
    typedef struct packed {
        logic signed [15:0] beta;
        logic signed [15:0] alpha;
        logic signed [7:0]  needed_depth;
        logic [7:0]         ply;
        logic [1:0]         new_flag;
        logic signed [7:0]  new_depth;
        logic [15:0]        new_move;
        logic signed [15:0] new_score;
        logic [KEY_W-1:0]   key;
    } item_t;

    // Outcome of one probe or store against the slot that was read.
    typedef struct packed {
        logic   usable;
        logic   matched;
        logic   written;
        data_t  found;
        slot_t  new_slot;
    } eval_t;

    // Control states of the top level.
    typedef enum logic [1:0] {
        ST_WIPE,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

FILE: design/dmsc_table.sv
// Slot memory of the search cache: one write port, one read port, registered read data.
// Depends on dmsc_pkg for the slot type.
module dmsc_table #(
    parameter int INDEX_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [INDEX_BITS-1:0]   wr_addr,
    input  dmsc_pkg::slot_t         wr_data,
    input  logic [INDEX_BITS-1:0]   rd_addr,
    output dmsc_pkg::slot_t         rd_data
);
    import dmsc_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    slot_t mem [DEPTH];
    slot_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/dmsc_eval.sv
// Probe and store evaluation: key and depth match, cutoff test, mate adjustment
// and depth-preferred replacement decision. Depends on dmsc_pkg.
module dmsc_eval (
    input  logic [1:0]        kind,
    input  dmsc_pkg::item_t   item,
    input  dmsc_pkg::slot_t   slot,
    output dmsc_pkg::eval_t   res
);
    import dmsc_pkg::*;

    logic signed [16:0] score_ext;
    logic signed [16:0] ply_ext;
    logic signed [16:0] adj_sum;
    logic signed [15:0] adj_score;
    logic               hit;
    logic               replace;

    // Mate adjustment by ply, saturated to 16 bits.
    always_comb begin
        score_ext = {item.new_score[15], item.new_score};
        ply_ext   = {9'd0, item.ply};
        if (score_ext > MATE_LIMIT) begin
            adj_sum = score_ext + ply_ext;
        end else if (score_ext < -MATE_LIMIT) begin
            adj_sum = score_ext - ply_ext;
        end else begin
            adj_sum = score_ext;
        end
        if (adj_sum > SCORE_MAX) begin
            adj_score = 16'sh7FFF;
        end else if (adj_sum < SCORE_MIN) begin
            adj_score = 16'sh8000;
        end else begin
            adj_score = adj_sum[15:0];
        end
    end

    // Match and replacement tests against the stored slot.
    assign hit     = (slot.key == item.key) && (slot.data.depth >= item.needed_depth);
    assign replace = (slot.key == '0) || (slot.data.depth <= item.new_depth);

    // Result fields; new_slot is always filled from the item, anything else without meaning for the operation is zero.
    always_comb begin
        res = '0;
        res.new_slot.key        = item.key;
        res.new_slot.data.score = adj_score;
        res.new_slot.data.move  = item.new_move;
        res.new_slot.data.depth = item.new_depth;
        res.new_slot.data.flag  = item.new_flag;
        case (kind)
            KIND_PROBE: begin
                if (hit) begin
                    res.matched = 1'b1;
                    res.found   = slot.data;
                    case (slot.data.flag)
                        FLAG_EXACT: res.usable = 1'b1;
                        FLAG_UPPER: res.usable = (slot.data.score <= item.alpha);
                        FLAG_LOWER: res.usable = (slot.data.score >= item.beta);
                        default:    res.usable = 1'b0;
                    endcase
                end
            end
            KIND_STORE: begin
                res.written = replace;
            end
            default: begin
                res.written = 1'b0;
            end
        endcase
    end

endmodule

FILE: design/direct_mapped_search_cache.sv
// Probe or store: the slot is read as the item is accepted; in ST_LOOKUP the result is registered
// and the slot written back once the output is free, and no new item is taken until then.
// Clear: one slot zeroed per cycle over every slot, then the result.
// Reset (aresetn low, synchronous) starts a clearing pass over every slot of
// the slot memory; s_tready stays low until it ends. The write counter resets to zero.
module direct_mapped_search_cache #(
    parameter int INDEX_BITS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // key[63:0], new_score[79:64], new_move[95:80], new_depth[103:96], new_flag[105:104],
    // ply[113:106], needed_depth[121:114], alpha[137:122], beta[153:138], zeros above
    input  logic [dmsc_pkg::IN_TDATA_W-1:0]         s_tdata,
    // kind[1:0]
    input  logic [1:0]                              s_tuser,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // found_score[15:0], found_move[31:16], found_depth[39:32], found_flag[41:40],
    // write_count[73:42], zeros above
    output logic [dmsc_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // usable[0], matched[1], written[2]
    output logic [dmsc_pkg::OUT_TUSER_W-1:0]        m_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready
);
    import dmsc_pkg::*;

    localparam logic [INDEX_BITS-1:0] LAST_SLOT = '1;

    state_t                  state_reg, state_next;
    logic [INDEX_BITS-1:0]   wipe_addr_reg, wipe_addr_next;
    logic                    wipe_boot_reg, wipe_boot_next;
    logic [1:0]              kind_reg, kind_next;
    item_t                   item_reg, item_next;
    logic [31:0]             count_reg, count_next;
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0]  m_tuser_reg, m_tuser_next;

    item_t                   in_item;
    logic                    in_accept;
    logic                    out_free;
    logic                    emit;
    logic                    mem_we;
    logic [INDEX_BITS-1:0]   mem_waddr;
    slot_t                   mem_wdata;
    logic [INDEX_BITS-1:0]   mem_raddr;
    slot_t                   mem_rdata;
    eval_t                   ev;

    assign in_item   = s_tdata[$bits(item_t)-1:0];
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // Slot memory; reads the incoming item's slot while idle, the held item's slot otherwise.
    assign mem_raddr = (state_reg == ST_IDLE) ? in_item.key[INDEX_BITS-1:0]
                                               : item_reg.key[INDEX_BITS-1:0];

    dmsc_table #(
        .INDEX_BITS (INDEX_BITS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    dmsc_eval u_eval (
        .kind (kind_reg),
        .item (item_reg),
        .slot (mem_rdata),
        .res  (ev)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_WIPE: begin
                if (wipe_addr_reg == LAST_SLOT) begin
                    state_next = wipe_boot_reg ? ST_IDLE : ST_LOOKUP;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = (s_tuser == KIND_CLEAR) ? ST_WIPE : ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the controller: handshake, memory writes, result emission.
    always_comb begin
        s_tready  = 1'b0;
        emit      = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = item_reg.key[INDEX_BITS-1:0];
        mem_wdata = ev.new_slot;
        case (state_reg)
            ST_WIPE: begin
                mem_we    = 1'b1;
                mem_waddr = wipe_addr_reg;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_LOOKUP: begin
                emit   = out_free;
                mem_we = out_free && ev.written;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb begin
        wipe_addr_next = wipe_addr_reg;
        wipe_boot_next = wipe_boot_reg;
        kind_next      = kind_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // Clearing pass walks the slots one per cycle.
        if (state_reg == ST_WIPE) begin
            wipe_addr_next = wipe_addr_reg + INDEX_BITS'(1);
        end

        // Capture the accepted item; a clear zeroes the counter up front.
        if (in_accept) begin
            kind_next = s_tuser;
            item_next = in_item;
            if (s_tuser == KIND_CLEAR) begin
                count_next     = '0;
                wipe_addr_next = '0;
                wipe_boot_next = 1'b0;
            end
        end

        // Result goes to the output register, counting a replaced slot.
        if (emit) begin
            count_next   = count_reg + {31'd0, ev.written};
            m_valid_next = 1'b1;
            m_tdata_next = {6'd0, count_next, ev.found};
            m_tuser_next = {ev.written, ev.matched, ev.usable};
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_WIPE;
            wipe_addr_reg <= '0;
            wipe_boot_reg <= 1'b1;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wipe_addr_reg <= wipe_addr_next;
            wipe_boot_reg <= wipe_boot_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        item_reg    <= item_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: bench/direct_mapped_search_cache_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for direct_mapped_search_cache: a directed table, then random
// probes, stores and clears checked against a predictor of the slot table.
// Depends on dmsc_pkg and the direct_mapped_search_cache RTL.
module direct_mapped_search_cache_tb;
    import dmsc_pkg::*;

    localparam int INDEX_BITS   = 16;
    localparam int SLOT_COUNT   = 1 << INDEX_BITS;
    localparam int HALF_PERIOD  = 10;
    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_ITEMS  = 150;
    localparam int LONG_HOLD    = 120;
    localparam int STALL_LIMIT  = 300000;
    localparam int END_SLACK    = 16;
    localparam int TAG_W        = KEY_W - INDEX_BITS;

    // Codes that the package leaves out.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] FLAG_UNUSED = 2'd3;

    // One expected or observed result item.
    typedef struct packed {
        logic        usable;
        logic        matched;
        logic [15:0] score;
        logic [15:0] move;
        logic [7:0]  depth;
        logic [1:0]  flag;
        logic        written;
        logic [31:0] count;
    } answer_t;

    // One row of the directed table; want is used only where typed is set.
    typedef struct {
        logic [1:0] kind;
        item_t      item;
        bit         typed;
        answer_t    want;
    } row_t;

    logic                   aclk;
    logic                   aresetn;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tvalid;
    logic                   m_tready;

    // Predicted contents of the slot table and the store counter.
    logic [KEY_W-1:0] slot_key_tab [SLOT_COUNT];
    data_t            slot_data_tab [SLOT_COUNT];
    logic [31:0]      store_total;

    answer_t          pending_answers [$];
    int               mismatches;
    int               stalled_cycles;
    int               clears_left;
    bit               quiet_tail;
    bit               hold_request;
    logic [TAG_W-1:0]      tag_pool [6];
    logic [INDEX_BITS-1:0] slot_pool [12];

    direct_mapped_search_cache #(
        .INDEX_BITS(INDEX_BITS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Free-running clock, 20 ns period.
    always begin
        aclk = 1'b0;
        #(HALF_PERIOD);
        aclk = 1'b1;
        #(HALF_PERIOD);
    end

    // Prints one line per wrong or unexpected field and counts it.
    task automatic note_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    endtask

    // Works out the result of one item and updates the predicted table.
    function automatic answer_t cache_answer(logic [1:0] kind, item_t item);
        answer_t res;
        int      slot;
        int      adjusted;
        data_t   entry;
        res = '0;
        slot = int'(item.key[INDEX_BITS-1:0]);
        entry = slot_data_tab[slot];
        case (kind)
            KIND_PROBE: begin
                if (slot_key_tab[slot] == item.key &&
                    $signed(entry.depth) >= $signed(item.needed_depth)) begin
                    res.matched = 1'b1;
                    res.score = entry.score;
                    res.move = entry.move;
                    res.depth = entry.depth;
                    res.flag = entry.flag;
                    case (entry.flag)
                        FLAG_EXACT: res.usable = 1'b1;
                        FLAG_UPPER: res.usable = $signed(entry.score) <= $signed(item.alpha);
                        FLAG_LOWER: res.usable = $signed(entry.score) >= $signed(item.beta);
                        default:    res.usable = 1'b0;
                    endcase
                end
            end
            KIND_STORE: begin
                // Mate scores move away from zero by ply, then saturate.
                adjusted = int'($signed(item.new_score));
                if (adjusted > int'(MATE_LIMIT)) begin
                    adjusted = adjusted + int'(item.ply);
                end else if (adjusted < -int'(MATE_LIMIT)) begin
                    adjusted = adjusted - int'(item.ply);
                end
                if (adjusted > int'(SCORE_MAX)) adjusted = int'(SCORE_MAX);
                if (adjusted < int'(SCORE_MIN)) adjusted = int'(SCORE_MIN);
                // Depth-preferred replacement; an empty slot always takes the store.
                if (slot_key_tab[slot] == '0 ||
                    $signed(entry.depth) <= $signed(item.new_depth)) begin
                    slot_key_tab[slot] = item.key;
                    slot_data_tab[slot].score = adjusted[15:0];
                    slot_data_tab[slot].move = item.new_move;
                    slot_data_tab[slot].depth = item.new_depth;
                    slot_data_tab[slot].flag = item.new_flag;
                    store_total = store_total + 32'd1;
                    res.written = 1'b1;
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    slot_key_tab[i] = '0;
                    slot_data_tab[i] = '0;
                end
                store_total = '0;
            end
            default: ;
        endcase
        res.count = store_total;
        return res;
    endfunction

    function automatic item_t build_request(logic [63:0] key, int score, int move, int depth,
                                            int flag, int ply, int need, int alpha, int beta);
        item_t item;
        item.key = key;
        item.new_score = score[15:0];
        item.new_move = move[15:0];
        item.new_depth = depth[7:0];
        item.new_flag = flag[1:0];
        item.ply = ply[7:0];
        item.needed_depth = need[7:0];
        item.alpha = alpha[15:0];
        item.beta = beta[15:0];
        return item;
    endfunction

    function automatic answer_t spell_answer(bit usable, bit matched, int score, int move,
                                             int depth, int flag, bit written, int count);
        answer_t res;
        res.usable = usable;
        res.matched = matched;
        res.score = score[15:0];
        res.move = move[15:0];
        res.depth = depth[7:0];
        res.flag = flag[1:0];
        res.written = written;
        res.count = count;
        return res;
    endfunction

    // Draws a random item; keys mostly come from small pools so that slots collide.
    task automatic draw_request(output logic [1:0] kind, output item_t item);
        int pick;
        pick = $urandom_range(0, 99);
        if (clears_left > 0 && $urandom_range(0, 399) == 0) begin
            kind = KIND_CLEAR;
            clears_left--;
        end else if (pick < 46) begin
            kind = KIND_PROBE;
        end else if (pick < 96) begin
            kind = KIND_STORE;
        end else begin
            kind = KIND_UNUSED;
        end
        if ($urandom_range(0, 9) == 0) begin
            item.key = {$urandom, $urandom};
        end else begin
            item.key = {tag_pool[$urandom_range(0, 5)], slot_pool[$urandom_range(0, 11)]};
        end
        case ($urandom_range(0, 5))
            0: item.new_score = 16'(20000 + $urandom_range(0, 6) - 3);
            1: item.new_score = 16'(-20000 + $urandom_range(0, 6) - 3);
            2: item.new_score = 16'(32767 - $urandom_range(0, 300));
            3: item.new_score = 16'(-32768 + $urandom_range(0, 300));
            default: item.new_score = 16'($urandom);
        endcase
        item.new_move = 16'($urandom);
        item.new_depth = 8'($urandom);
        item.new_flag = 2'($urandom_range(0, 3));
        item.ply = 8'($urandom);
        item.needed_depth = 8'($urandom);
        item.alpha = 16'($urandom);
        item.beta = 16'($urandom);
    endtask

    // Offers one item, records its expected result on acceptance, then maybe idles.
    task automatic offer_item(logic [1:0] kind, item_t item, bit typed, answer_t want);
        answer_t predicted;
        @(negedge aclk);
        s_tuser <= kind;
        s_tdata <= {{(IN_TDATA_W - $bits(item_t)){1'b0}}, item};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = cache_answer(kind, item);
        pending_answers.push_back(typed ? want : predicted);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge aclk);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int held;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++) @(negedge aclk);
                hold_request = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compares each returned item with the oldest expectation.
    always @(posedge aclk) begin : check_results
        answer_t got;
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.usable = m_tuser[0];
            got.matched = m_tuser[1];
            got.written = m_tuser[2];
            got.score = m_tdata[15:0];
            got.move = m_tdata[31:16];
            got.depth = m_tdata[39:32];
            got.flag = m_tdata[41:40];
            got.count = m_tdata[73:42];
            if (pending_answers.size() == 0) begin
                note_mismatch("result with nothing pending", got.count, 0);
            end else begin
                want = pending_answers.pop_front();
                if (got.usable !== want.usable) note_mismatch("usable", got.usable, want.usable);
                if (got.matched !== want.matched)
                    note_mismatch("matched", got.matched, want.matched);
                if (got.score !== want.score) note_mismatch("found_score", got.score, want.score);
                if (got.move !== want.move) note_mismatch("found_move", got.move, want.move);
                if (got.depth !== want.depth) note_mismatch("found_depth", got.depth, want.depth);
                if (got.flag !== want.flag) note_mismatch("found_flag", got.flag, want.flag);
                if (got.written !== want.written)
                    note_mismatch("written", got.written, want.written);
                if (got.count !== want.count) note_mismatch("write_count", got.count, want.count);
            end
        end
    end

    // Ends the run when no item moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
        end
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Reset, directed table, random items, then drain.
    initial begin : stimulus
        row_t       script [$];
        logic [1:0] kind;
        item_t      item;
        logic [63:0] k1, k2, k3, k4, k5, k0b;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_PROBE;
        quiet_tail = 1'b0;
        hold_request = 1'b0;
        mismatches = 0;
        stalled_cycles = 0;
        clears_left = 2;
        store_total = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_key_tab[i] = '0;
            slot_data_tab[i] = '0;
        end
        // Key pools include the all-zero and all-one extremes.
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 6; i++) tag_pool[i] = TAG_W'({$urandom, $urandom});
        slot_pool[0] = '0;
        slot_pool[1] = '1;
        for (int i = 2; i < 12; i++) slot_pool[i] = INDEX_BITS'($urandom);

        k1 = 64'h0123_4567_89AB_0010;
        k2 = 64'hFEDC_BA98_7654_0010;
        k3 = 64'h8000_0000_0000_0020;
        k4 = 64'h7FFF_FFFF_FFFF_0030;
        k5 = 64'h5555_AAAA_5555_0040;
        k0b = 64'h0000_0000_0001_0000;

        // Empty table: key zero matches the blank entry only for non-positive depth.
        script.push_back('{KIND_PROBE, build_request(0, 0, 0, 0, 0, 0, 0, 0, 0),
                          1'b1, spell_answer(1, 1, 0, 0, 0, FLAG_EXACT, 0, 0)});
        script.push_back('{KIND_PROBE, build_request(0, 0, 0, 0, 0, 0, 1, 0, 0),
                          1'b1, spell_answer(0, 0, 0, 0, 0, 0, 0, 0)});
        script.push_back('{KIND_PROBE, build_request('1, 0, 0, 0, 0, 0, -128, 0, 0),
                          1'b1, spell_answer(0, 0, 0, 0, 0, 0, 0, 0)});
        // Mate score at the top saturates.
        script.push_back('{KIND_STORE, build_request(k1, 32767, 'hFFFF, 5, FLAG_EXACT, 255,
                          0, 0, 0), 1'b1, spell_answer(0, 0, 0, 0, 0, 0, 1, 1)});
        script.push_back('{KIND_PROBE, build_request(k1, 0, 0, 0, 0, 0, 5, 0, 0),
                          1'b1, spell_answer(1, 1, 32767, 'hFFFF, 5, FLAG_EXACT, 0, 1)});
        // Shallower store to the same slot is refused; equal depth replaces.
        script.push_back('{KIND_STORE, build_request(k2, -32768, 0, 4, FLAG_UPPER, 1,
                          0, 0, 0), 1'b1, spell_answer(0, 0, 0, 0, 0, 0, 0, 1)});
        script.push_back('{KIND_STORE, build_request(k2, -32768, 0, 5, FLAG_UPPER, 1,
                          0, 0, 0), 1'b1, spell_answer(0, 0, 0, 0, 0, 0, 1, 2)});
        script.push_back('{KIND_PROBE, build_request(k1, 0, 0, 0, 0, 0, -128, 0, 0),
                          1'b1, spell_answer(0, 0, 0, 0, 0, 0, 0, 2)});
        script.push_back('{KIND_PROBE, build_request(k2, 0, 0, 0, 0, 0, 5, -32768, 32767),
                          1'b0, '0});
        // Lower bound just past the mate limit, tested at and above its score.
        script.push_back('{KIND_STORE, build_request(k3, 20001, 'h1234, -128, FLAG_LOWER, 10,
                          0, 0, 0), 1'b0, '0});
        script.push_back('{KIND_PROBE, build_request(k3, 0, 0, 0, 0, 0, -128, 0, 20011),
                          1'b0, '0});
        script.push_back('{KIND_PROBE, build_request(k3, 0, 0, 0, 0, 0, -128, 0, 20012),
                          1'b0, '0});
        script.push_back('{KIND_PROBE, build_request(k3, 0, 0, 0, 0, 0, -127, 0, 0),
                          1'b0, '0});
        // Flag three is kept and never usable.
        script.push_back('{KIND_STORE, build_request(k4, -20001, 'h8001, 127, FLAG_UNUSED,
                          255, 0, 0, 0), 1'b0, '0});
        script.push_back('{KIND_PROBE, build_request(k4, 0, 0, 0, 0, 0, 127, 32767, -32768),
                          1'b0, '0});
        // Score exactly at the mate limit is not adjusted.
        script.push_back('{KIND_STORE, build_request(k5, 20000, 'h00FF, 0, FLAG_UPPER, 50,
                          0, 0, 0), 1'b0, '0});
        script.push_back('{KIND_PROBE, build_request(k5, 0, 0, 0, 0, 0, 0, 19999, 0),
                          1'b0, '0});
        script.push_back('{KIND_PROBE, build_request(k5, 0, 0, 0, 0, 0, 0, 20000, 0),
                          1'b0, '0});
        // Stores with key zero leave the slot looking empty to the next store.
        script.push_back('{KIND_STORE, build_request(0, -20000, 'hAAAA, -128, FLAG_LOWER, 7,
                          0, 0, 0), 1'b0, '0});
        script.push_back('{KIND_PROBE, build_request(0, 0, 0, 0, 0, 0, -128, 0, -20000),
                          1'b0, '0});
        script.push_back('{KIND_STORE, build_request(k0b, 0, 'h5555, -128, FLAG_EXACT, 0,
                          0, 0, 0), 1'b0, '0});
        script.push_back('{KIND_UNUSED, build_request(k1, -1, 'hFFFF, -1, 3, 255, -1, -1, -1),
                          1'b0, '0});
        script.push_back('{KIND_CLEAR, build_request(k1, 0, 0, 0, 0, 0, 0, 0, 0),
                          1'b1, spell_answer(0, 0, 0, 0, 0, 0, 0, 0)});
        script.push_back('{KIND_PROBE, build_request(k5, 0, 0, 0, 0, 0, -128, 0, 0),
                          1'b1, spell_answer(0, 0, 0, 0, 0, 0, 0, 0)});
        script.push_back('{KIND_PROBE, build_request(0, 0, 0, 0, 0, 0, 0, 0, 0),
                          1'b1, spell_answer(1, 1, 0, 0, 0, FLAG_EXACT, 0, 0)});

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) offer_item(script[i].kind, script[i].item, script[i].typed,
                                       script[i].want);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // The result side backs up while items keep coming.
            if (i == 200) hold_request = 1'b1;
            // Sender pauses until every pending result has returned.
            if (i == 600) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (pending_answers.size() != 0) @(posedge aclk);
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
            draw_request(kind, item);
            offer_item(kind, item, 1'b0, '0);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain; the watchdog covers a result that never comes.
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (END_SLACK) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: direct_mapped_search_cache.f
design/dmsc_pkg.sv
design/dmsc_table.sv
design/dmsc_eval.sv
design/direct_mapped_search_cache.sv
bench/direct_mapped_search_cache_tb.sv
